>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, prop, msg)
`endif
`endif

>>> hw/rtl/srts_pkg.sv
// Package with types and constants of the sorted record table search block.
package srts_pkg;
  localparam int Capacity  = 64;
  localparam int NameChars = 9;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int RecW      = 82;
  localparam logic [63:0] TailMask =
    (NameChars >= 9) ? 64'hFFFF_FFFF_FFFF_FFFF :
    (NameChars <= 1) ? 64'h0 : (64'hFFFF_FFFF_FFFF_FFFF << (8 * (9 - NameChars)));

  typedef enum logic [1:0] {
    OpClear = 2'd0, OpAppend = 2'd1, OpSort = 2'd2, OpSearch = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StMatch = 2'd0, StNotFound = 2'd1, StFull = 2'd2, StUnsorted = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SSortRd, SSortCmp, SSearchRd, SSearchCmp,
    SScanRd, SScanChk, SScanOut, SStatus
  } state_e;

  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] tail;
    logic [9:0]  score;
  } rec_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       set_sorted;
    logic       sort_init;
    logic       sort_rd;
    logic       sort_step;
    logic       srch_init;
    logic       srch_rd;
    logic       srch_step;
    logic       scan_rd;
    logic       scan_next;
    logic       load_rec;
    logic       load_status;
    status_e    status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;
    logic sorted;
    logic sort_done;
    logic srch_done;
    logic scan_hit;
    logic scan_more;
  } stat_t;
endpackage

>>> hw/rtl/srts_if.sv
// Valid/ready channel interfaces for input and result items.
interface srts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  name_head;
  logic [63:0] name_tail;
  logic [9:0]  score;
  modport source (output valid, operation, name_head, name_tail, score, input ready);
  modport sink (input valid, operation, name_head, name_tail, score, output ready);
endinterface

interface srts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  name_head_res;
  logic [63:0] name_tail_res;
  logic [9:0]  score_res;
  logic        last;
  modport source (output valid, status, name_head_res, name_tail_res, score_res, last,
                  input ready);
  modport sink (input valid, status, name_head_res, name_tail_res, score_res, last,
                output ready);
endinterface

>>> hw/rtl/srts_datapath.sv
// Datapath: record memory, sort and search index registers, result register.
module srts_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srts_pkg::cmd_t  cmd_i,
  output srts_pkg::stat_t stat_o,
  input  logic [7:0]      head_i,
  input  logic [63:0]     tail_i,
  input  logic [9:0]      score_i,
  input  logic            res_take_i,
  output logic            res_valid_o,
  output logic [1:0]      res_status_o,
  output srts_pkg::rec_t  res_rec_o,
  output logic            res_last_o
);
  import srts_pkg::*;

  rec_t mem_q [Capacity];
  rec_t rd_a_q, rd_b_q;
  logic [CntW-1:0] cnt_q;
  logic sorted_q;
  // Insertion sort: i outer, j inner, compares entry j with j-1.
  logic [CntW-1:0] i_q, j_q;
  logic [CntW-1:0] lo_q, hi_q, idx_q;
  logic [9:0] key_q;
  logic res_valid_q, res_last_q;
  logic [1:0] res_status_q;
  rec_t res_rec_q;

  logic [CntW:0] mid_w;
  logic [IdxW-1:0] mid;
  logic [IdxW-1:0] ra, rb;
  logic goes_first;
  logic swap;

  assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
  assign mid   = mid_w[IdxW-1:0];

  always_comb begin
    ra = j_q[IdxW-1:0];
    rb = j_q[IdxW-1:0] - IdxW'(1);
    if (cmd_i.srch_rd) ra = mid;
    if (cmd_i.scan_rd) begin
      ra = idx_q[IdxW-1:0];
      rb = idx_q[IdxW-1:0] + IdxW'(1);
    end
  end

  // Entry j goes before entry j-1.
  always_comb begin
    if (rd_a_q.score != rd_b_q.score) goes_first = rd_a_q.score > rd_b_q.score;
    else goes_first = {rd_a_q.head, rd_a_q.tail} < {rd_b_q.head, rd_b_q.tail};
  end
  assign swap = cmd_i.sort_step && (j_q != '0) && goes_first;

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[ra];
    rd_b_q <= mem_q[rb];
    if (cmd_i.append) begin
      mem_q[cnt_q[IdxW-1:0]] <= '{head: head_i, tail: tail_i & TailMask, score: score_i};
    end else if (swap) begin
      mem_q[j_q[IdxW-1:0]] <= rd_b_q;
      mem_q[j_q[IdxW-1:0] - IdxW'(1)] <= rd_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sorted_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      idx_q <= '0;
      key_q <= '0;
      res_valid_q <= 1'b0;
      res_last_q <= 1'b0;
      res_status_q <= '0;
      res_rec_q <= '0;
    end else begin
      if (cmd_i.load_rec || cmd_i.load_status) res_valid_q <= 1'b1;
      else if (res_take_i) res_valid_q <= 1'b0;
      if (cmd_i.clear) begin
        cnt_q <= '0;
        sorted_q <= 1'b0;
      end
      if (cmd_i.append) begin
        cnt_q <= cnt_q + CntW'(1);
        sorted_q <= 1'b0;
      end
      if (cmd_i.set_sorted) sorted_q <= 1'b1;
      if (cmd_i.sort_init) begin
        i_q <= CntW'(1);
        j_q <= CntW'(1);
      end
      if (cmd_i.sort_step) begin
        if (swap) j_q <= j_q - CntW'(1);
        else begin
          i_q <= i_q + CntW'(1);
          j_q <= i_q + CntW'(1);
        end
      end
      if (cmd_i.srch_init) begin
        lo_q <= '0;
        hi_q <= cnt_q;
        idx_q <= '0;
        key_q <= score_i;
      end
      // The scan index follows the lower bound of the search.
      if (cmd_i.srch_step) begin
        if (rd_a_q.score > key_q) begin
          lo_q <= mid_w[CntW-1:0] + CntW'(1);
          idx_q <= mid_w[CntW-1:0] + CntW'(1);
        end else hi_q <= mid_w[CntW-1:0];
      end
      if (cmd_i.scan_next) idx_q <= idx_q + CntW'(1);
      if (cmd_i.load_rec) begin
        res_status_q <= StMatch;
        res_rec_q <= rd_a_q;
        res_last_q <= !stat_o.scan_more;
      end
      if (cmd_i.load_status) begin
        res_status_q <= cmd_i.status;
        res_rec_q <= '0;
        res_last_q <= 1'b1;
      end
    end
  end

  assign stat_o.full      = cnt_q >= CntW'(Capacity);
  assign stat_o.sorted    = sorted_q;
  assign stat_o.sort_done = i_q >= cnt_q;
  assign stat_o.srch_done = lo_q >= hi_q;
  assign stat_o.scan_hit  = (idx_q < cnt_q) && (rd_a_q.score == key_q);
  assign stat_o.scan_more = (idx_q + CntW'(1) < cnt_q) && (rd_b_q.score == key_q);

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_rec_o    = res_rec_q;
  assign res_last_o   = res_last_q;
endmodule

>>> hw/rtl/srts_ctrl.sv
// Controller state machine sequencing sort, search and result delivery.
module srts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srts_pkg::op_e   op_i,
  input  srts_pkg::stat_t stat_i,
  input  logic            res_valid_i,
  output srts_pkg::cmd_t  cmd_o
);
  import srts_pkg::*;

  state_e state_q, state_d;
  status_e st_q, st_d;
  logic acc;

  assign in_ready_o = (state_q == SIdle) && !res_valid_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    unique case (state_q)
      SIdle: if (acc) begin
        unique case (op_i)
          OpClear: state_d = SIdle;
          OpAppend: if (stat_i.full) begin
            st_d = StFull;
            state_d = SStatus;
          end
          OpSort: state_d = SSortRd;
          OpSearch: if (!stat_i.sorted) begin
            st_d = StUnsorted;
            state_d = SStatus;
          end else state_d = SSearchRd;
          default: state_d = SIdle;
        endcase
      end
      SSortRd: state_d = stat_i.sort_done ? SIdle : SSortCmp;
      SSortCmp: state_d = SSortRd;
      SSearchRd: state_d = stat_i.srch_done ? SScanRd : SSearchCmp;
      SSearchCmp: state_d = SSearchRd;
      SScanRd: state_d = SScanChk;
      SScanChk: if (stat_i.scan_hit) state_d = SScanOut;
        else begin
          st_d = StNotFound;
          state_d = SStatus;
        end
      SScanOut: if (!res_valid_i) state_d = stat_i.scan_more ? SScanRd : SIdle;
      SStatus: if (!res_valid_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = st_q;
    unique case (state_q)
      SIdle: begin
        cmd_o.clear = acc && (op_i == OpClear);
        cmd_o.append = acc && (op_i == OpAppend) && !stat_i.full;
        cmd_o.sort_init = acc && (op_i == OpSort);
        cmd_o.srch_init = acc && (op_i == OpSearch);
      end
      SSortRd: begin
        cmd_o.sort_rd = 1'b1;
        cmd_o.set_sorted = stat_i.sort_done;
      end
      SSortCmp: cmd_o.sort_step = 1'b1;
      SSearchRd: cmd_o.srch_rd = !stat_i.srch_done;
      SSearchCmp: cmd_o.srch_step = 1'b1;
      SScanRd: cmd_o.scan_rd = 1'b1;
      SScanChk: cmd_o.scan_rd = 1'b1;
      SScanOut: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.load_rec = !res_valid_i;
        cmd_o.scan_next = !res_valid_i;
      end
      SStatus: cmd_o.load_status = !res_valid_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      st_q <= StNotFound;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
    end
  end
endmodule

>>> hw/rtl/sorted_record_table_search.sv
// Sorted record table search: top level joining controller and datapath.
// Clear and append act when accepted; a full append or unsorted search gives a status result.
// Sort is an insertion sort; each compare has a read state (SSortRd) and a step state (SSortCmp).
// Search: read, compare per binary probe (log2 N probes); per result: scan read, check, output.
// One item is in work at a time; results wait in one output register.
// Reset empties the table and marks it unsorted; record memory is not cleared.
module sorted_record_table_search (
  input logic         clk_i,
  input logic         rst_ni,
  srts_in_if.sink     in_i,
  srts_out_if.source  out_o
);
  import srts_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  stat_t stat;
  rec_t rec;
  logic res_valid, take;

  assign take = out_o.valid && out_o.ready;

  srts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .op_i(op_e'(in_i.operation)), .stat_i(stat),
    .res_valid_i(res_valid && !take), .cmd_o(cmd)
  );

  srts_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .head_i(in_i.name_head), .tail_i(in_i.name_tail), .score_i(in_i.score),
    .res_take_i(take), .res_valid_o(res_valid), .res_status_o(out_o.status),
    .res_rec_o(rec), .res_last_o(out_o.last)
  );

  assign out_o.valid = res_valid;
  assign out_o.name_head_res = rec.head;
  assign out_o.name_tail_res = rec.tail;
  assign out_o.score_res = rec.score;

  `ASSERT_NEVER(a_no_accept_while_busy, in_i.ready && out_o.valid && !out_o.ready,
                "input accepted while a result waits")
  `ASSERT_IMPL(a_status_zero_fields, out_o.valid && out_o.status != StMatch |->
               out_o.score_res == '0 && out_o.last, "status-only result not clean")
  `ASSERT_IMPL(a_hold, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.status),
               "result dropped while stalled")
endmodule
